// File: rtl/pwm_prescale_period_calc_defines.svh
// Assertion macros for the block that checks itself.
`ifndef PWM_PRESCALE_PERIOD_CALC_DEFINES_SVH
`define PWM_PRESCALE_PERIOD_CALC_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PWMPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwmpc same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PWMPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwmpc next-cycle check failed");

`endif

// File: rtl/pwmpc_pkg.sv
`default_nettype none

package pwmpc_pkg;

  localparam int unsigned CODES      = 16;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned CH_W       = 1;
  localparam int unsigned CHANNELS   = 2;
  localparam int unsigned PERIOD_W   = 31;
  localparam int unsigned PS_W       = 41;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned TICK_W     = 32;
  // Quotient bits 17..0; bit 17 set means the count saturates.
  localparam int unsigned QW         = 18;
  localparam int unsigned SH_W       = TICK_W + QW - 1;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = (QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_W      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_CYCLE,
    REG_LEGACY
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_IGNORED,
    ST_BYPASS,
    ST_NOFIT
  } status_t;

  localparam logic [PERIOD_W-1:0] BYPASS_NS   = 31'd84;
  localparam logic [9:0]          PS_PER_NS   = 10'd1000;
  localparam logic [CNT_W-1:0]    MIN_COUNT   = 16'd2;
  localparam logic [CNT_W-1:0]    MAX_RESET   = 16'hFFFF;
  localparam logic [TICK_W-1:0]   TICK_LEGACY = 32'd3000000000;

  // Tick length in ps per prescaler code at 24 MHz: floor(1e6 * divisor / 24).
  localparam logic [TICK_W-1:0] TICK_PS [CODES] = '{
    32'd5000000,    32'd7500000,    32'd10000000,   32'd15000000,
    32'd20000000,   32'd20000000,   32'd20000000,   32'd20000000,
    32'd500000000,  32'd1000000000, 32'd1500000000, 32'd2000000000,
    32'd3000000000, 32'd3000000000, 32'd3000000000, 32'd41666
  };

  function automatic logic [TICK_W-1:0] tick_of(input logic [CODE_W-1:0] code,
                                                input logic legacy);
    logic [TICK_W-1:0] t;
    t = TICK_PS[code];
    if (code == CODE_W'(CODES - 1) && legacy) t = TICK_LEGACY;
    return t;
  endfunction

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [PERIOD_W-1:0] period_len;
    logic [PERIOD_W-1:0] duty_ns;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [CH_W-1:0]     channel_out;
    logic [CODE_W-1:0]   prescale_index;
    logic [CNT_W-1:0]    total_ticks;
    logic [CNT_W-1:0]    high_ticks;
  } rsp_t;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    status_t         status;
    logic [PS_W-1:0] period_ps;
    logic [PS_W-1:0] duty_ps;
  } front_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    status_t          status;
    logic [PS_W-1:0]  period_ps;
    logic [PS_W-1:0]  duty_ps;
    logic [CODES-1:0] pass1;
    logic [CODES-1:0] pass2;
  } match_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    status_t           status;
    logic [CODE_W-1:0] code;
    logic [TICK_W-1:0] tick;
    logic [PS_W-1:0]   rem_p;
    logic [PS_W-1:0]   rem_d;
    logic [QW-1:0]     q_p;
    logic [QW-1:0]     q_d;
  } div_t;

endpackage

`default_nettype wire

// File: rtl/pwm_prescale_period_calc.sv
// Pipeline: 13 register stages (front, match, select, 9 divider stages, output).
// Throughput: one request per cycle while rsp_stall is low; the restoring divider resolves two
//   quotient bits per stage over 9 stages for both tick counts.
// Reset: clears every stage valid bit, sets max_cycle_count to 65535 and legacy_soc to 0.
`default_nettype none
`include "pwm_prescale_period_calc_defines.svh"

module pwm_prescale_period_calc import pwmpc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire req_t                 req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output rsp_t                      rsp
);

  localparam int unsigned DIV_STG0 = 3;
  localparam int unsigned NST      = DIV_STG0 + DIV_STAGES + 1;
  localparam int unsigned OUT_STG  = NST - 1;

  logic [CNT_W-1:0] max_cycle_count;
  logic             legacy_soc;
  logic [NST-1:0]   vld;
  logic [NST-1:0]   adv;
  front_t           front_q;
  match_t           match_q;
  div_t             div_pipe [DIV_STAGES+1];
  rsp_t             rsp_next;
  logic             rsp_fields_zero;
  logic             rsp_counts_min;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_cycle_count <= MAX_RESET;
      legacy_soc      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_CYCLE: max_cycle_count <= cfg_data;
        REG_LEGACY:    legacy_soc      <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // A stage advances when it is empty or the stage after it advances
  always_comb begin
    adv[OUT_STG] = !vld[OUT_STG] || !rsp_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign req_stall = !adv[0];
  assign rsp_valid = vld[OUT_STG];

  // Valid bits travel with each beat
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= req_valid;
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  pwmpc_front u_front (
    .clk        (clk),
    .load       (adv[0]),
    .legacy_soc (legacy_soc),
    .r          (req),
    .f          (front_q)
  );

  pwmpc_match u_match (
    .clk             (clk),
    .load            (adv[1]),
    .max_cycle_count (max_cycle_count),
    .legacy_soc      (legacy_soc),
    .f               (front_q),
    .m               (match_q)
  );

  pwmpc_select u_select (
    .clk        (clk),
    .load       (adv[2]),
    .legacy_soc (legacy_soc),
    .m          (match_q),
    .d          (div_pipe[0])
  );

  // Divider stages, highest quotient bits first
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int TOP = int'(QW) - 1 - j * int'(DIV_STEPS);
    localparam int NSTEP = (TOP + 1 < int'(DIV_STEPS)) ? TOP + 1 : int'(DIV_STEPS);
    pwmpc_div_step #(
      .TOP_BIT (TOP),
      .STEPS   (NSTEP)
    ) u_step (
      .clk  (clk),
      .load (adv[DIV_STG0 + j]),
      .d    (div_pipe[j]),
      .q    (div_pipe[j+1])
    );
  end

  // Clamp counts to at most max, then raise them to at least 2, and zero the fields of any non-ok result
  always_comb begin
    div_t             last;
    logic [CNT_W-1:0] ent;
    logic [CNT_W-1:0] act;
    last = div_pipe[DIV_STAGES];
    ent = (last.q_p > QW'(max_cycle_count)) ? max_cycle_count : last.q_p[CNT_W-1:0];
    act = (last.q_d > QW'(max_cycle_count)) ? max_cycle_count : last.q_d[CNT_W-1:0];
    if (ent < MIN_COUNT) ent = MIN_COUNT;
    if (act < MIN_COUNT) act = MIN_COUNT;
    rsp_next.status      = last.status;
    rsp_next.channel_out = last.channel;
    if (last.status == ST_OK) begin
      rsp_next.prescale_index = last.code;
      rsp_next.total_ticks    = ent;
      rsp_next.high_ticks     = act;
    end else begin
      rsp_next.prescale_index = '0;
      rsp_next.total_ticks    = '0;
      rsp_next.high_ticks     = '0;
    end
  end

  // Output register; holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (adv[OUT_STG]) rsp <= rsp_next;
  end

  assign rsp_fields_zero = rsp.prescale_index == '0 && rsp.total_ticks == '0 &&
                           rsp.high_ticks == '0;
  assign rsp_counts_min  = rsp.total_ticks >= MIN_COUNT && rsp.high_ticks >= MIN_COUNT;

  `PWMPC_ASSERT_NOW(a_nonok_zero, clk, rst, rsp_valid && rsp.status != ST_OK, rsp_fields_zero)
  `PWMPC_ASSERT_NOW(a_ok_min_count, clk, rst, rsp_valid && rsp.status == ST_OK, rsp_counts_min)
  `PWMPC_ASSERT_NEXT(a_accept_enters, clk, rst, req_valid && !req_stall, vld[0])

endmodule

`default_nettype wire

// File: rtl/pwmpc_front.sv
`default_nettype none

module pwmpc_front import pwmpc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   load,
  input  wire logic   legacy_soc,
  input  wire req_t   r,
  output front_t      f
);

  front_t f_next;

  // Classify the request and scale both times to picoseconds
  always_comb begin
    f_next.channel   = r.channel;
    f_next.period_ps = PS_W'(r.period_len) * PS_W'(PS_PER_NS);
    f_next.duty_ps   = PS_W'(r.duty_ns) * PS_W'(PS_PER_NS);
    if (r.period_len == '0 || r.duty_ns == '0 ||
        {{(32-CH_W){1'b0}}, r.channel} >= 32'(CHANNELS)) begin
      f_next.status = ST_IGNORED;
    end else if (!legacy_soc && r.period_len < BYPASS_NS) begin
      f_next.status = ST_BYPASS;
    end else begin
      f_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (load) f <= f_next;
  end

endmodule

`default_nettype wire

// File: rtl/pwmpc_match.sv
`default_nettype none

module pwmpc_match import pwmpc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic [CNT_W-1:0]  max_cycle_count,
  input  wire logic              legacy_soc,
  input  wire front_t            f,
  output match_t                 m
);

  // Per-code bounds: q >= max/2 <=> p >= (max/2)*t ; q <= max <=> p < (max+1)*t
  logic [SH_W-1:0] lo_thr [CODES];
  logic [SH_W-1:0] hi_thr [CODES];
  match_t          m_next;

  // Track the configuration; the user must change it only while the pipeline is empty (not enforced here)
  always_ff @(posedge clk) begin
    for (int i = 0; i < CODES; i++) begin
      lo_thr[i] <= SH_W'(max_cycle_count >> 1) * SH_W'(tick_of(CODE_W'(i), legacy_soc));
      hi_thr[i] <= SH_W'({1'b0, max_cycle_count} + 17'd1) *
                   SH_W'(tick_of(CODE_W'(i), legacy_soc));
    end
  end

  // Test every code in its own lane
  always_comb begin
    logic [SH_W-1:0] p;
    logic [SH_W-1:0] t;
    p = SH_W'(f.period_ps);
    m_next.channel   = f.channel;
    m_next.status    = f.status;
    m_next.period_ps = f.period_ps;
    m_next.duty_ps   = f.duty_ps;
    for (int i = 0; i < CODES; i++) begin
      t = SH_W'(tick_of(CODE_W'(i), legacy_soc));
      m_next.pass1[i] = (p >= t) && (p >= lo_thr[i]) && (p < hi_thr[i]);
      m_next.pass2[i] = (p >= (t << 1)) && (p < hi_thr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) m <= m_next;
  end

endmodule

`default_nettype wire

// File: rtl/pwmpc_select.sv
`default_nettype none

module pwmpc_select import pwmpc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   load,
  input  wire logic   legacy_soc,
  input  wire match_t m,
  output div_t        d
);

  div_t d_next;

  // Take the highest passing code, first pass before fallback, and seed the division
  always_comb begin
    logic [CODES-1:0]  hits;
    logic [CODE_W-1:0] code;
    logic [TICK_W-1:0] tick;
    hits = (m.pass1 != '0) ? m.pass1 : m.pass2;
    code = '0;
    for (int i = 0; i < CODES; i++) begin
      if (hits[i]) code = CODE_W'(i);
    end
    tick = tick_of(code, legacy_soc);
    d_next.channel = m.channel;
    d_next.status  = m.status;
    if (m.status == ST_OK && hits == '0) d_next.status = ST_NOFIT;
    d_next.code  = code;
    d_next.tick  = tick;
    // Add half a tick so the truncating division rounds to nearest
    d_next.rem_p = m.period_ps + PS_W'(tick[TICK_W-1:1]);
    d_next.rem_d = m.duty_ps + PS_W'(tick[TICK_W-1:1]);
    d_next.q_p   = '0;
    d_next.q_d   = '0;
  end

  always_ff @(posedge clk) begin
    if (load) d <= d_next;
  end

endmodule

`default_nettype wire

// File: rtl/pwmpc_div_step.sv
`default_nettype none

module pwmpc_div_step import pwmpc_pkg::*; #(
  parameter int TOP_BIT = 17,
  parameter int STEPS   = 2
) (
  input  wire logic clk,
  input  wire logic load,
  input  wire div_t d,
  output div_t      q
);

  div_t q_next;

  // Resolve STEPS quotient bits of both divisions, highest bit first
  always_comb begin
    logic [SH_W-1:0] trial;
    q_next = d;
    for (int s = 0; s < STEPS; s++) begin
      trial = SH_W'(d.tick) << (TOP_BIT - s);
      if (SH_W'(q_next.rem_p) >= trial) begin
        q_next.rem_p = q_next.rem_p - trial[PS_W-1:0];
        q_next.q_p[TOP_BIT - s] = 1'b1;
      end
      if (SH_W'(q_next.rem_d) >= trial) begin
        q_next.rem_d = q_next.rem_d - trial[PS_W-1:0];
        q_next.q_d[TOP_BIT - s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) q <= q_next;
  end

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none

module tb_top import pwmpc_pkg::*; ();

  // Hold-off length for the back-pressure burst, and the watchdog limit on
  // cycles in which neither side moves a beat.
  localparam int HOLD_LEN   = 200;
  localparam int STALL_STOP = 3000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  cfg_reg_t             cfg_index = REG_MAX_CYCLE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;

  pwm_prescale_period_calc dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Predicts each answer from its request and the current register values,
  // and checks answers in order against the predictions.
  class pwm_calc_scoreboard;
    logic [CFG_W-1:0] max_count;
    bit               legacy;
    rsp_t             expected_q[$];
    int               errors;
    int               checked;
    int               by_status[4];

    function new();
      max_count = 16'hFFFF;
      legacy    = 1'b0;
      errors    = 0;
      checked   = 0;
      for (int i = 0; i < 4; i++) by_status[i] = 0;
    endfunction

    // Tick length in ps of one prescaler code at 24 MHz.
    function longint unsigned tick_len(int code);
      longint unsigned div;
      case (code)
        0:              div = 120;
        1:              div = 180;
        2:              div = 240;
        3:              div = 360;
        4, 5, 6, 7:     div = 480;
        8:              div = 12000;
        9:              div = 24000;
        10:             div = 36000;
        11:             div = 48000;
        12, 13, 14:     div = 72000;
        default:        div = legacy ? 72000 : 1;
      endcase
      return 64'd1000000 * div / 64'd24;
    endfunction

    // Highest code whose floor quotient lands in [lo, hi], or -1.
    function int pick_code(longint unsigned period_ps, longint unsigned lo,
                           longint unsigned hi);
      int best;
      longint unsigned t;
      longint unsigned q;
      best = -1;
      for (int i = 0; i < CODES; i++) begin
        t = tick_len(i);
        if (t != 0 && t <= period_ps) begin
          q = period_ps / t;
          if (q >= lo && q <= hi) best = i;
        end
      end
      return best;
    endfunction

    // Round to nearest tick, then clamp to max and raise to two.
    function logic [CNT_W-1:0] to_ticks(int code, longint unsigned ns);
      longint unsigned t;
      longint unsigned c;
      t = tick_len(code);
      c = (ns * 64'd1000 + t / 64'd2) / t;
      if (c > 64'(max_count)) c = 64'(max_count);
      if (c < 64'd2) c = 64'd2;
      return c[CNT_W-1:0];
    endfunction

    function rsp_t predict(req_t r);
      rsp_t            e;
      longint unsigned period_ps;
      int              code;
      e.status         = ST_IGNORED;
      e.channel_out    = r.channel;
      e.prescale_index = '0;
      e.total_ticks    = '0;
      e.high_ticks     = '0;
      if (r.period_len == 0 || r.duty_ns == 0 || r.channel >= CHANNELS) return e;
      // Under two 24 MHz clock periods the counter is bypassed.
      if (!legacy && r.period_len < 31'd84) begin
        e.status = ST_BYPASS;
        return e;
      end
      period_ps = 64'(r.period_len) * 64'd1000;
      code = pick_code(period_ps, 64'(max_count / 2), 64'(max_count));
      if (code < 0) code = pick_code(period_ps, 64'd2, 64'(max_count));
      if (code < 0) begin
        e.status = ST_NOFIT;
        return e;
      end
      e.status         = ST_OK;
      e.prescale_index = code[CODE_W-1:0];
      e.total_ticks    = to_ticks(code, 64'(r.period_len));
      e.high_ticks     = to_ticks(code, 64'(r.duty_ns));
      return e;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      e = predict(r);
      by_status[e.status]++;
      expected_q.push_back(e);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected answer beat, expected none, actual %h", $time, got);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      compare_field("status", 32'(e.status), 32'(got.status));
      compare_field("channel_out", 32'(e.channel_out), 32'(got.channel_out));
      compare_field("prescale_index", 32'(e.prescale_index), 32'(got.prescale_index));
      compare_field("total_ticks", 32'(e.total_ticks), 32'(got.total_ticks));
      compare_field("high_ticks", 32'(e.high_ticks), 32'(got.high_ticks));
    endfunction
  endclass

  pwm_calc_scoreboard sb = new();

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int settings_run = 1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Answer side: check accepted beats, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_LEN - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Stop a hung run: count cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_STOP) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_STOP);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic req_t mk(bit ch, longint unsigned p, longint unsigned d);
    req_t r;
    r.channel    = ch;
    r.period_len = p[PERIOD_W-1:0];
    r.duty_ns    = d[PERIOD_W-1:0];
    return r;
  endfunction

  // Spread values evenly over bit lengths 1..31.
  function automatic longint unsigned log_spread();
    int k;
    k = int'($urandom_range(31, 1));
    return (64'd1 << (k - 1)) | (64'($urandom) & ((64'd1 << (k - 1)) - 64'd1));
  endfunction

  function automatic req_t random_request();
    int              pick;
    int              code;
    longint unsigned p;
    longint unsigned d;
    longint unsigned q;
    pick = int'($urandom_range(99));
    if (pick < 3) begin
      p = 0;
    end else if (pick < 8) begin
      p = 64'($urandom_range(100, 1));
    end else if (pick < 40) begin
      // Land on a quotient edge of some code for the current max.
      code = int'($urandom_range(15));
      case ($urandom_range(3))
        0:       q = 64'(sb.max_count);
        1:       q = 64'(sb.max_count / 2);
        2:       q = 2;
        default: q = 64'(sb.max_count) + 64'd1;
      endcase
      p = q * sb.tick_len(code) / 64'd1000;
      if (p > 0) p = p - 64'd1 + 64'($urandom_range(2));
    end else begin
      p = log_spread();
    end
    if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
    pick = int'($urandom_range(99));
    if (pick < 3) d = 0;
    else if (pick < 45) d = p * 64'($urandom_range(300)) / 64'd256;
    else if (pick < 55) d = p;
    else d = log_spread();
    if (d > 64'h7FFF_FFFF) d = 64'h7FFF_FFFF;
    return mk(1'($urandom_range(1)), p, d);
  endfunction

  // Offer one beat after a random gap; hold it until accepted.
  task automatic send_request(input req_t item);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    sb.note_request(item);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 70; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 70; end
      default: begin idle_pct = 16; stall_pct = 16; end
    endcase
  endtask

  task automatic run_random(input int n);
    for (int mode = 0; mode < 4; mode++) begin
      set_idling(mode);
      repeat (n / 4) send_request(random_request());
    end
    req_valid <= 1'b0;
  endtask

  task automatic send_list(input req_t items[$]);
    set_idling(3);
    foreach (items[i]) send_request(items[i]);
    req_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait out every prediction, then at least the pipeline depth.
  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // Write both registers back to back; only called while drained.
  task automatic configure(input logic [CFG_W-1:0] max_val, input bit legacy_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_CYCLE;
    cfg_data  <= max_val;
    @(posedge clk);
    cfg_index <= REG_LEGACY;
    cfg_data  <= CFG_W'(legacy_val);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.max_count = max_val;
    sb.legacy    = legacy_val;
    settings_run++;
    @(posedge clk);
  endtask

  initial begin
    req_t dir[$];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset registers: ignored, bypass edge, extremes, duty past period.
    dir = '{mk(0, 0, 500), mk(1, 1000, 0), mk(0, 0, 0), mk(1, 1, 1), mk(0, 83, 40),
            mk(1, 84, 42), mk(0, 64'h7FFF_FFFF, 64'h7FFF_FFFF),
            mk(1, 1000000, 64'h7FFF_FFFF), mk(0, 2730000, 1365000),
            mk(1, 20000000, 10000000), mk(0, 100000000, 1), mk(1, 1365000, 700000)};
    send_list(dir);

    // Hold the answer side off while requests keep coming, so the pipe backs up.
    set_idling(0);
    hold_requests++;
    repeat (60) send_request(random_request());
    run_random(240);
    wait_drained();

    // Legacy part: no bypass, slowest code on entry 15.
    configure(16'd255, 1'b1);
    dir = '{mk(0, 1, 1), mk(1, 83, 10), mk(0, 9999, 5000), mk(1, 10000, 5000),
            mk(0, 1275000, 637500), mk(1, 64'h7FFF_FFFF, 1),
            mk(0, 765000000, 64'h7FFF_FFFF)};
    send_list(dir);
    run_random(200);
    wait_drained();

    // Max below two: first pass may still fit and counts read two.
    configure(16'd1, 1'b1);
    dir = '{mk(0, 5000, 2500), mk(1, 7000, 9000), mk(0, 4999, 100)};
    send_list(dir);
    wait_drained();
    configure(16'd0, 1'b0);
    dir = '{mk(1, 100000, 5000), mk(0, 84, 84)};
    send_list(dir);
    wait_drained();

    configure(16'd2, 1'b0);
    run_random(120);
    wait_drained();

    for (int i = 0; i < 6; i++) begin
      if (i == 0) configure(16'hFFFF, 1'b1);
      else if (i == 1) configure(16'd2, 1'b1);
      else configure(CFG_W'($urandom_range(65535, 2)), 1'($urandom_range(1)));
      run_random(56);
      wait_drained();
    end

    $display("Checked %0d answers over %0d register settings, with idle and stall mixes",
             sb.checked, settings_run);
    $display("Outcomes: %0d ok, %0d ignored, %0d bypass, %0d no fit", sb.by_status[ST_OK],
             sb.by_status[ST_IGNORED], sb.by_status[ST_BYPASS], sb.by_status[ST_NOFIT]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/pwmpc_pkg.sv
rtl/pwmpc_front.sv
rtl/pwmpc_match.sv
rtl/pwmpc_select.sv
rtl/pwmpc_div_step.sv
rtl/pwm_prescale_period_calc.sv
sim/tb_top.sv
